/* hw/rtl/chb_pkg.sv */
// Shared constants and types of the client heartbeat table.
// Used by client_heartbeat_table; depends on nothing else.
`default_nettype none

package chb_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_BYTES   = 8;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int KEY_W       = 8 * KEY_BYTES;
  localparam int LEN_W       = 4;
  localparam int TIME_W      = 32;
  localparam int TIMEOUT_W   = 16;
  localparam int FUNC_W      = 2;
  localparam int KIND_W      = 3;

  localparam int IN_TDATA_W  = ((KEY_W + LEN_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ADDR_W + 1 + KEY_W + 7) / 8) * 8;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CONNECT = 2'd0,
    FUNC_BEAT    = 2'd1,
    FUNC_SWEEP   = 2'd2
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FORWARD   = 3'd0,
    KIND_ECHO      = 3'd1,
    KIND_DISCONN   = 3'd2,
    KIND_REFUSED   = 3'd3,
    KIND_UNKNOWN   = 3'd4,
    KIND_SWEEP_END = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/client_heartbeat_table.sv */
// Liveness table of up to TABLE_DEPTH clients with a single sequential scan unit.
// Depends on chb_pkg.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser func, tdata key/length/now
//  m_axis    out  tvalid/tready/tlast    tuser kind, tdata slot/reconnected/key
//  cfg       in   cfg_we_i               cfg_wdata_i timeout in seconds
//
// An item is accepted, scanned entry by entry through the single table read port and
// compare unit (stopping early when a lookup matches) and then closed; a sweep also
// emits a disconnected result for each timed-out client before it closes.
// Reset clears the state machine, the connected flags, the entry count and the
// output valid flag; the table stores are not cleared. A stalled output holds the
// scan at its next result; the input is ready only while the block is idle.
`default_nettype none

module client_heartbeat_table (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [chb_pkg::TIMEOUT_W-1:0]   cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: client_key, key_length, now, zero padding
  input  wire logic [chb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func
  input  wire logic [chb_pkg::FUNC_W-1:0]      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata from bit 0: slot, reconnected, key_out, zero padding
  output logic [chb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // tuser: kind
  output logic [chb_pkg::KIND_W-1:0]           m_axis_tuser,
  output logic                                 m_axis_tlast
);

  import chb_pkg::*;

  logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];
  logic [TIME_W-1:0] time_mem [TABLE_DEPTH];

  state_e                 state_q, state_d;
  logic [TIMEOUT_W-1:0]   timeout_q;
  logic [TABLE_DEPTH-1:0] alive_q;
  logic [COUNT_W-1:0]     count_q;
  logic [COUNT_W-1:0]     idx_q, idx_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]      rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0]      hit_idx_q, hit_idx_d;
  logic [KEY_W-1:0]       rd_key_q;
  logic [LEN_W-1:0]       rd_len_q;
  logic [TIME_W-1:0]      rd_time_q;

  func_e                  func_q;
  logic [KEY_W-1:0]       key_q;
  logic [LEN_W-1:0]       len_q;
  logic [TIME_W-1:0]      now_q;

  logic                   m_valid_q;
  kind_e                  m_kind_q, out_kind;
  logic [ADDR_W-1:0]      m_slot_q, out_slot;
  logic                   m_again_q, out_again;
  logic [KEY_W-1:0]       m_key_q, out_key;
  logic                   m_last_q, out_last;

  logic                   s_accept, out_free, out_load, load_op, rd_en;
  logic                   time_we, entry_we, alive_set, alive_clr, count_inc;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   scan_hit, table_full;
  logic [TIME_W-1:0]      age;
  logic [LEN_W-1:0]       in_len, sat_len;
  logic [KEY_W-1:0]       in_mask;

  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_valid_q || m_axis_tready;
  assign table_full = (count_q == COUNT_W'(TABLE_DEPTH));

  // Length saturation and byte masking of the incoming key.
  assign in_len  = s_axis_tdata[KEY_W +: LEN_W];
  assign sat_len = (in_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_len;

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      in_mask[8*b +: 8] = (LEN_W'(b) < sat_len) ? 8'hFF : 8'h00;
    end
  end

  // The shared compare unit: key match for lookups, age test for sweeps.
  assign age = now_q - rd_time_q;

  always_comb begin
    case (func_q)
      FUNC_SWEEP: scan_hit = alive_q[rd_idx_q] && (age > TIME_W'(timeout_q));
      default:    scan_hit = (rd_len_q == len_q) && (rd_key_q == key_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      timeout_q <= TIMEOUT_RESET;
      alive_q   <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (alive_set) begin
        alive_q[wr_addr] <= 1'b1;
      end else if (alive_clr) begin
        alive_q[wr_addr] <= 1'b0;
      end
      if (count_inc) begin
        count_q <= count_q + COUNT_W'(1);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    hit_idx_q <= hit_idx_d;
    if (load_op) begin
      func_q <= func_e'(s_axis_tuser);
      key_q  <= s_axis_tdata[KEY_W-1:0] & in_mask;
      len_q  <= sat_len;
      now_q  <= s_axis_tdata[KEY_W+LEN_W +: TIME_W];
    end
    if (out_load) begin
      m_kind_q  <= out_kind;
      m_slot_q  <= out_slot;
      m_again_q <= out_again;
      m_key_q   <= out_key;
      m_last_q  <= out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_key_q  <= key_mem[rd_idx_d];
      rd_len_q  <= len_mem[rd_idx_d];
      rd_time_q <= time_mem[rd_idx_d];
    end
    if (entry_we) begin
      key_mem[wr_addr] <= key_q;
      len_mem[wr_addr] <= len_q;
    end
    if (time_we) begin
      time_mem[wr_addr] <= now_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    hit_idx_d = hit_idx_q;
    rd_en     = 1'b0;
    load_op   = 1'b0;
    out_load  = 1'b0;
    out_kind  = KIND_FORWARD;
    out_slot  = '0;
    out_again = 1'b0;
    out_key   = '0;
    out_last  = 1'b1;
    time_we   = 1'b0;
    entry_we  = 1'b0;
    alive_set = 1'b0;
    alive_clr = 1'b0;
    count_inc = 1'b0;
    wr_addr   = hit_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          load_op = 1'b1;
          idx_d   = '0;
          unique case (s_axis_tuser) inside
            FUNC_CONNECT, FUNC_BEAT, FUNC_SWEEP: state_d = ST_SCAN;
            default:                             state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && scan_hit) begin
          hit_idx_d = rd_idx_q;
          idx_d     = COUNT_W'(rd_idx_q) + COUNT_W'(1);
          state_d   = ST_ACT;
        end else if (idx_q < count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[ADDR_W-1:0];
          idx_d    = idx_q + COUNT_W'(1);
        end else if (!rd_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_ACT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_slot = hit_idx_q;
          out_key  = rd_key_q;
          unique case (func_q)
            FUNC_CONNECT: begin
              out_kind  = KIND_FORWARD;
              out_again = 1'b1;
              time_we   = 1'b1;
              alive_set = 1'b1;
              state_d   = ST_IDLE;
            end
            FUNC_BEAT: begin
              out_kind = KIND_ECHO;
              time_we  = 1'b1;
              state_d  = ST_IDLE;
            end
            default: begin
              out_kind  = KIND_DISCONN;
              out_last  = 1'b0;
              alive_clr = 1'b1;
              state_d   = ST_SCAN;
            end
          endcase
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          unique case (func_q)
            FUNC_CONNECT: begin
              if (table_full) begin
                out_kind = KIND_REFUSED;
              end else begin
                wr_addr   = count_q[ADDR_W-1:0];
                entry_we  = 1'b1;
                time_we   = 1'b1;
                alive_set = 1'b1;
                count_inc = 1'b1;
                out_kind  = KIND_FORWARD;
                out_slot  = count_q[ADDR_W-1:0];
                out_key   = key_q;
              end
            end
            FUNC_BEAT: out_kind = KIND_UNKNOWN;
            default:   out_kind = KIND_SWEEP_END;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = OUT_TDATA_W'({m_key_q, m_again_q, m_slot_q});

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_hit_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACT |-> COUNT_W'(hit_idx_q) < count_q)
    else $error("matched slot outside the filled table");

  a_only_disconn_midrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_last_q |-> m_kind_q == KIND_DISCONN)
    else $error("non-final result of a kind other than disconnected");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && out_free |=> state_q == ST_IDLE)
    else $error("closing result did not end the item");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_inc |=> count_q == $past(count_q) + COUNT_W'(1) && alive_q[$past(wr_addr)])
    else $error("appended entry not counted or not connected");

endmodule

`default_nettype wire
